### src/crps_pkg.sv
// shared types, constants and tables for the catmull-rom path smoother
package crps_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int MAX_STEPS_DEF  = 31;

  localparam int STEPS_W    = 5;
  localparam int SAMPLE_W   = 14;
  localparam int DIR_W      = 13;
  localparam int T_W        = 17;
  localparam int Q_FRAC     = 16;
  localparam int G_W        = 22;
  localparam int FRAC_SHIFT = 17;

  localparam logic [STEPS_W-1:0] STEPS_RESET = 5'd10;
  localparam logic [T_W-1:0]     ONE_Q16     = 17'h10000;

  typedef struct packed {
    logic load;
    logic issue;
    logic seg;
    logic first;
    logic run_last;
    logic path_done;
  } cmd_t;

  typedef struct packed {
    logic               adv;
    logic               front_empty;
    logic               seen_ge1;
    logic               seen_ge2;
    logic [STEPS_W-1:0] eff_n;
  } sts_t;

  // floor(65536 / n)
  function automatic logic [T_W-1:0] recip_q(input logic [STEPS_W-1:0] n);
    logic [T_W-1:0] q;
    unique case (n)
      5'd1:    q = 17'd65536;
      5'd2:    q = 17'd32768;
      5'd3:    q = 17'd21845;
      5'd4:    q = 17'd16384;
      5'd5:    q = 17'd13107;
      5'd6:    q = 17'd10922;
      5'd7:    q = 17'd9362;
      5'd8:    q = 17'd8192;
      5'd9:    q = 17'd7281;
      5'd10:   q = 17'd6553;
      5'd11:   q = 17'd5957;
      5'd12:   q = 17'd5461;
      5'd13:   q = 17'd5041;
      5'd14:   q = 17'd4681;
      5'd15:   q = 17'd4369;
      5'd16:   q = 17'd4096;
      5'd17:   q = 17'd3855;
      5'd18:   q = 17'd3640;
      5'd19:   q = 17'd3449;
      5'd20:   q = 17'd3276;
      5'd21:   q = 17'd3120;
      5'd22:   q = 17'd2978;
      5'd23:   q = 17'd2849;
      5'd24:   q = 17'd2730;
      5'd25:   q = 17'd2621;
      5'd26:   q = 17'd2520;
      5'd27:   q = 17'd2427;
      5'd28:   q = 17'd2340;
      5'd29:   q = 17'd2259;
      5'd30:   q = 17'd2184;
      5'd31:   q = 17'd2114;
      default: q = 17'd65536;
    endcase
    return q;
  endfunction

endpackage

### src/crps_ctrl.sv
// controller: request intake and per-segment sample sequencing
module crps_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_path_last,
  output logic            in_stall,
  input  crps_pkg::sts_t  sts,
  output crps_pkg::cmd_t  cmd
);
  import crps_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_ISSUE, ST_DRAIN} state_t;

  state_t             state_r, state_nxt;
  logic [STEPS_W-1:0] j_r, j_nxt;
  logic               seg_r, seg_nxt;
  logic               need_b_r, need_b_nxt;
  logic               last_r, last_nxt;
  logic               in_stall_r;
  logic               accept;
  logic               seg_a;
  logic               seg_b;
  logic               j_end;
  logic               more_b;

  assign accept = in_valid && !in_stall_r;
  assign seg_a  = sts.seen_ge2;
  assign seg_b  = in_path_last && sts.seen_ge1;
  assign j_end  = (j_r == sts.eff_n);
  assign more_b = !seg_r && need_b_r;

  always_comb begin
    cmd.load      = accept;
    cmd.issue     = (state_r == ST_ISSUE);
    cmd.seg       = seg_r;
    cmd.first     = (j_r == '0);
    cmd.run_last  = j_end && !more_b;
    cmd.path_done = j_end && !more_b && last_r;
  end

  always_comb begin
    state_nxt  = state_r;
    j_nxt      = j_r;
    seg_nxt    = seg_r;
    need_b_nxt = need_b_r;
    last_nxt   = last_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          last_nxt   = in_path_last;
          need_b_nxt = seg_b;
          j_nxt      = '0;
          if (seg_a) begin
            seg_nxt   = 1'b0;
            state_nxt = ST_ISSUE;
          end else if (seg_b) begin
            seg_nxt   = 1'b1;
            state_nxt = ST_ISSUE;
          end
        end
      end
      ST_ISSUE: begin
        if (sts.adv) begin
          if (j_end) begin
            j_nxt = '0;
            if (more_b) begin
              seg_nxt = 1'b1;
            end else begin
              state_nxt = ST_DRAIN;
            end
          end else begin
            j_nxt = j_r + STEPS_W'(1);
          end
        end
      end
      ST_DRAIN: begin
        // segment points must stay put until the pipeline front has read them
        if (sts.front_empty) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      j_r        <= '0;
      seg_r      <= 1'b0;
      need_b_r   <= 1'b0;
      last_r     <= 1'b0;
      in_stall_r <= 1'b1;
    end else begin
      state_r    <= state_nxt;
      j_r        <= j_nxt;
      seg_r      <= seg_nxt;
      need_b_r   <= need_b_nxt;
      last_r     <= last_nxt;
      in_stall_r <= (state_nxt != ST_IDLE);
    end
  end

  assign in_stall = in_stall_r;

endmodule

### src/crps_dp.sv
// datapath: path state, parameter table, basis and blending pipeline, output register
module crps_dp #(
  parameter int COORD_BITS = crps_pkg::COORD_BITS_DEF,
  parameter int MAX_STEPS  = crps_pkg::MAX_STEPS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [crps_pkg::STEPS_W-1:0]        cfg_wr_data,
  input  logic [COORD_BITS-1:0]               in_point_x,
  input  logic [COORD_BITS-1:0]               in_point_y,
  input  logic                                in_path_last,
  input  crps_pkg::cmd_t                      cmd,
  output crps_pkg::sts_t                      sts,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [crps_pkg::SAMPLE_W-1:0] out_sample_x,
  output logic signed [crps_pkg::SAMPLE_W-1:0] out_sample_y,
  output logic signed [crps_pkg::DIR_W-1:0]    out_dir_x,
  output logic signed [crps_pkg::DIR_W-1:0]    out_dir_y,
  output logic                                out_run_last,
  output logic                                out_path_done
);
  import crps_pkg::*;

  localparam int PROD_W = G_W + COORD_BITS + 1;
  localparam int SUM_W  = PROD_W + 2;
  localparam int DIFF_W = COORD_BITS + DIR_W + 1;
  localparam int QN_W   = T_W + STEPS_W;
  localparam logic [2*T_W-1:0] RND_HALF   = (2*T_W)'(1) << (Q_FRAC - 1);
  localparam logic [SUM_W-1:0] TRUNC_BIAS = (SUM_W'(1) << FRAC_SHIFT) - SUM_W'(1);

  typedef struct packed {
    logic seg;
    logic run_last;
    logic path_done;
  } tag_t;

  function automatic logic [DIR_W-1:0] dir_of(input logic [COORD_BITS-1:0] a,
                                               input logic [COORD_BITS-1:0] b);
    logic [DIFF_W-1:0] d;
    d = DIFF_W'(a) - DIFF_W'(b);
    return d[DIR_W-1:0];
  endfunction

  // ---------------- steps register and derived constants
  logic [STEPS_W-1:0] steps_r;
  logic [STEPS_W-1:0] eff_nxt;
  logic [T_W-1:0]     q_nxt;
  logic [QN_W-1:0]    qn;
  logic [QN_W-1:0]    rem_full;
  logic [STEPS_W-1:0] eff_n_r;
  logic [T_W-1:0]     q_r;
  logic [STEPS_W-1:0] rem_r;
  logic [STEPS_W-1:0] half_r;

  always_comb begin
    eff_nxt = steps_r;
    if (eff_nxt == '0) eff_nxt = STEPS_W'(1);
    if (eff_nxt > STEPS_W'(MAX_STEPS)) eff_nxt = STEPS_W'(MAX_STEPS);
    q_nxt    = recip_q(eff_nxt);
    qn       = QN_W'(q_nxt) * QN_W'(eff_nxt);
    rem_full = QN_W'(ONE_Q16) - qn;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      steps_r <= STEPS_RESET;
    end else if (cfg_wr_en) begin
      steps_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    eff_n_r <= eff_nxt;
    q_r     <= q_nxt;
    rem_r   <= rem_full[STEPS_W-1:0];
    half_r  <= eff_nxt >> 1;
  end

  // ---------------- path state
  logic [1:0]            seen_r;
  logic [COORD_BITS-1:0] rec_x_r [3];
  logic [COORD_BITS-1:0] rec_y_r [3];
  logic [COORD_BITS-1:0] first_x_r;
  logic [COORD_BITS-1:0] first_y_r;
  logic [COORD_BITS-1:0] sa_x_r [4];
  logic [COORD_BITS-1:0] sa_y_r [4];
  logic [COORD_BITS-1:0] sb_x_r [4];
  logic [COORD_BITS-1:0] sb_y_r [4];
  logic [DIR_W-1:0]      dir_ax_r, dir_ay_r, dir_bx_r, dir_by_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r    <= '0;
      first_x_r <= '0;
      first_y_r <= '0;
      for (int i = 0; i < 3; i++) begin
        rec_x_r[i] <= '0;
        rec_y_r[i] <= '0;
      end
    end else if (cmd.load) begin
      if (in_path_last) begin
        seen_r    <= '0;
        first_x_r <= '0;
        first_y_r <= '0;
        for (int i = 0; i < 3; i++) begin
          rec_x_r[i] <= '0;
          rec_y_r[i] <= '0;
        end
      end else begin
        if (seen_r == 2'd0) begin
          first_x_r <= in_point_x;
          first_y_r <= in_point_y;
        end
        rec_x_r[0] <= rec_x_r[1];
        rec_y_r[0] <= rec_y_r[1];
        rec_x_r[1] <= rec_x_r[2];
        rec_y_r[1] <= rec_y_r[2];
        rec_x_r[2] <= in_point_x;
        rec_y_r[2] <= in_point_y;
        if (seen_r != 2'd3) seen_r <= seen_r + 2'd1;
      end
    end
  end

  // control points of both segments a request can produce
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      // third point of the path: the first segment repeats its start point
      sa_x_r[0] <= (seen_r == 2'd2) ? first_x_r : rec_x_r[0];
      sa_y_r[0] <= (seen_r == 2'd2) ? first_y_r : rec_y_r[0];
      sa_x_r[1] <= rec_x_r[1];
      sa_y_r[1] <= rec_y_r[1];
      sa_x_r[2] <= rec_x_r[2];
      sa_y_r[2] <= rec_y_r[2];
      sa_x_r[3] <= in_point_x;
      sa_y_r[3] <= in_point_y;
      sb_x_r[0] <= (seen_r >= 2'd2) ? rec_x_r[1] : rec_x_r[2];
      sb_y_r[0] <= (seen_r >= 2'd2) ? rec_y_r[1] : rec_y_r[2];
      sb_x_r[1] <= rec_x_r[2];
      sb_y_r[1] <= rec_y_r[2];
      sb_x_r[2] <= in_point_x;
      sb_y_r[2] <= in_point_y;
      sb_x_r[3] <= in_point_x;
      sb_y_r[3] <= in_point_y;
      dir_ax_r  <= dir_of(rec_x_r[2], rec_x_r[1]);
      dir_ay_r  <= dir_of(rec_y_r[2], rec_y_r[1]);
      dir_bx_r  <= dir_of(in_point_x, rec_x_r[2]);
      dir_by_r  <= dir_of(in_point_y, rec_y_r[2]);
    end
  end

  // ---------------- pipeline
  logic adv;
  logic out_valid_r;
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  tag_t tag1_r, tag2_r, tag3_r, tag4_r, tag5_r, tag6_r;

  assign adv = !out_valid_r || !out_stall;

  // t = floor((j * 65536 + n/2) / n), stepped with quotient and remainder
  logic [T_W-1:0]     t_cur;
  logic [STEPS_W-1:0] rem_cur;
  logic [T_W-1:0]     q_sum;
  logic [STEPS_W:0]   r_sum;
  logic [T_W-1:0]     acc_q_r, acc_q_nxt;
  logic [STEPS_W-1:0] acc_rem_r, acc_rem_nxt;

  always_comb begin
    t_cur   = cmd.first ? '0 : acc_q_r;
    rem_cur = cmd.first ? half_r : acc_rem_r;
    r_sum   = {1'b0, rem_cur} + {1'b0, rem_r};
    q_sum   = t_cur + q_r;
    if (r_sum >= {1'b0, eff_n_r}) begin
      acc_rem_nxt = STEPS_W'(r_sum - {1'b0, eff_n_r});
      acc_q_nxt   = q_sum + T_W'(1);
    end else begin
      acc_rem_nxt = r_sum[STEPS_W-1:0];
      acc_q_nxt   = q_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && cmd.issue) begin
      acc_q_r   <= acc_q_nxt;
      acc_rem_r <= acc_rem_nxt;
    end
  end

  // stage 1: t
  logic [T_W-1:0] t1_r;
  // stage 2: t, t^2
  logic [2*T_W-1:0] sq_full;
  logic [T_W-1:0]   t2_r, sq2_r;
  // stage 3: t, t^2, t^3
  logic [2*T_W-1:0] cu_full;
  logic [T_W-1:0]   t3_r, sq3_r, cu3_r;
  // stage 4: doubled basis weights
  logic signed [G_W-1:0] te, t2e, t3e;
  logic signed [G_W-1:0] w_nxt [4];
  logic signed [G_W-1:0] w4_r [4];
  // stage 5: products
  logic [COORD_BITS-1:0]    px [4];
  logic [COORD_BITS-1:0]    py [4];
  logic signed [PROD_W-1:0] p5x_r [4];
  logic signed [PROD_W-1:0] p5y_r [4];
  logic [DIR_W-1:0]         d5x_r, d5y_r;
  // stage 6: sums
  logic signed [SUM_W-1:0] s6x_r, s6y_r;
  logic [DIR_W-1:0]        d6x_r, d6y_r;
  // output register
  logic [SUM_W-1:0]    bx, by;
  logic [SAMPLE_W-1:0] sx_r, sy_r;
  logic [DIR_W-1:0]    dox_r, doy_r;
  logic                rl_r, pd_r;

  always_comb begin
    sq_full = t1_r * t1_r + RND_HALF;
    cu_full = sq2_r * t2_r + RND_HALF;
    te      = G_W'(t3_r);
    t2e     = G_W'(sq3_r);
    t3e     = G_W'(cu3_r);
    w_nxt[0] = (t2e <<< 1) - t3e - te;
    w_nxt[1] = (t3e <<< 1) + t3e - (t2e <<< 2) - t2e + (G_W'(ONE_Q16) <<< 1);
    w_nxt[2] = (t2e <<< 2) + te - (t3e <<< 1) - t3e;
    w_nxt[3] = t3e - t2e;
    for (int i = 0; i < 4; i++) begin
      px[i] = tag4_r.seg ? sb_x_r[i] : sa_x_r[i];
      py[i] = tag4_r.seg ? sb_y_r[i] : sa_y_r[i];
    end
    // divide by 2^17 truncating toward zero
    bx = s6x_r + (s6x_r[SUM_W-1] ? TRUNC_BIAS : '0);
    by = s6y_r + (s6y_r[SUM_W-1] ? TRUNC_BIAS : '0);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t1_r   <= t_cur;
      tag1_r <= '{seg: cmd.seg, run_last: cmd.run_last, path_done: cmd.path_done};

      t2_r   <= t1_r;
      sq2_r  <= sq_full[Q_FRAC +: T_W];
      tag2_r <= tag1_r;

      t3_r   <= t2_r;
      sq3_r  <= sq2_r;
      cu3_r  <= cu_full[Q_FRAC +: T_W];
      tag3_r <= tag2_r;

      for (int i = 0; i < 4; i++) w4_r[i] <= w_nxt[i];
      tag4_r <= tag3_r;

      for (int i = 0; i < 4; i++) begin
        p5x_r[i] <= PROD_W'(w4_r[i]) * $signed(PROD_W'(px[i]));
        p5y_r[i] <= PROD_W'(w4_r[i]) * $signed(PROD_W'(py[i]));
      end
      d5x_r  <= tag4_r.seg ? dir_bx_r : dir_ax_r;
      d5y_r  <= tag4_r.seg ? dir_by_r : dir_ay_r;
      tag5_r <= tag4_r;

      s6x_r  <= SUM_W'(p5x_r[0]) + SUM_W'(p5x_r[1]) + SUM_W'(p5x_r[2]) + SUM_W'(p5x_r[3]);
      s6y_r  <= SUM_W'(p5y_r[0]) + SUM_W'(p5y_r[1]) + SUM_W'(p5y_r[2]) + SUM_W'(p5y_r[3]);
      d6x_r  <= d5x_r;
      d6y_r  <= d5y_r;
      tag6_r <= tag5_r;

      sx_r  <= bx[FRAC_SHIFT +: SAMPLE_W];
      sy_r  <= by[FRAC_SHIFT +: SAMPLE_W];
      dox_r <= d6x_r;
      doy_r <= d6y_r;
      rl_r  <= tag6_r.run_last;
      pd_r  <= tag6_r.path_done;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      v6_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v1_r        <= cmd.issue;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      v5_r        <= v4_r;
      v6_r        <= v5_r;
      out_valid_r <= v6_r;
    end
  end

  always_comb begin
    sts.adv         = adv;
    sts.front_empty = !(v1_r || v2_r || v3_r || v4_r);
    sts.seen_ge1    = (seen_r != 2'd0);
    sts.seen_ge2    = (seen_r >= 2'd2);
    sts.eff_n       = eff_n_r;
  end

  assign out_valid     = out_valid_r;
  assign out_sample_x  = $signed(sx_r);
  assign out_sample_y  = $signed(sy_r);
  assign out_dir_x     = $signed(dox_r);
  assign out_dir_y     = $signed(doy_r);
  assign out_run_last  = rl_r;
  assign out_path_done = pd_r;

endmodule

### src/catmull_rom_path_smoother.sv
// throughput: one sample per cycle while the output does not stall; a request with S samples
//   (effective steps+1, twice when a path-end request also closes the segment before it) holds the
//   input until the four-stage front of the sample pipeline has emptied, since the segment control
//   points are reloaded only after that
// a request that yields no samples does not hold the input; output stalls stretch all of these
// reset: synchronous active low; steps returns to 10 and the path state is cleared
module catmull_rom_path_smoother #(
  parameter int COORD_BITS = crps_pkg::COORD_BITS_DEF,
  parameter int MAX_STEPS  = crps_pkg::MAX_STEPS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic [crps_pkg::STEPS_W-1:0]         cfg_wr_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [COORD_BITS-1:0]                in_point_x,
  input  logic [COORD_BITS-1:0]                in_point_y,
  input  logic                                 in_path_last,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [crps_pkg::SAMPLE_W-1:0] out_sample_x,
  output logic signed [crps_pkg::SAMPLE_W-1:0] out_sample_y,
  output logic signed [crps_pkg::DIR_W-1:0]    out_dir_x,
  output logic signed [crps_pkg::DIR_W-1:0]    out_dir_y,
  output logic                                 out_run_last,
  output logic                                 out_path_done
);
  import crps_pkg::*;

  cmd_t cmd;
  sts_t sts;

  crps_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_path_last (in_path_last),
    .in_stall     (in_stall),
    .sts          (sts),
    .cmd          (cmd)
  );

  crps_dp #(
    .COORD_BITS (COORD_BITS),
    .MAX_STEPS  (MAX_STEPS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_point_x    (in_point_x),
    .in_point_y    (in_point_y),
    .in_path_last  (in_path_last),
    .cmd           (cmd),
    .sts           (sts),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_sample_x  (out_sample_x),
    .out_sample_y  (out_sample_y),
    .out_dir_x     (out_dir_x),
    .out_dir_y     (out_dir_y),
    .out_run_last  (out_run_last),
    .out_path_done (out_path_done)
  );

  a_done_is_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_path_done) |-> out_run_last)
    else $error("path_done without run_last");

  a_last_clears_path: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_path_last) |=> !sts.seen_ge1)
    else $error("path state not cleared after final point");

  a_first_point_counted: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && !in_path_last && !sts.seen_ge1)
      |=> (sts.seen_ge1 && !sts.seen_ge2))
    else $error("first point of path miscounted");

  a_intake_needs_empty_front: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> sts.front_empty)
    else $error("request taken while segment points still in use");

endmodule
